FILE: rtl/timed_event_table_sequencer_assert.svh
// Assertion macros shared by the checker.
`ifndef TIMED_EVENT_TABLE_SEQUENCER_ASSERT_SVH
`define TIMED_EVENT_TABLE_SEQUENCER_ASSERT_SVH
// implication checked every clock outside reset
`define TETS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TETS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/tets_pkg.sv
// Shared types and constants of the timed event table sequencer.
package tets_pkg;
  localparam int unsigned MaxEventsDef = 1024;
  localparam int unsigned MaxBurstDef  = 64;

  localparam logic [2:0] CmdClear   = 3'd0;
  localparam logic [2:0] CmdAppend  = 3'd1;
  localparam logic [2:0] CmdFinish  = 3'd2;
  localparam logic [2:0] CmdStart   = 3'd3;
  localparam logic [2:0] CmdAdvance = 3'd4;
  localparam logic [2:0] CmdTick    = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [31:0]        now_time;
    logic signed [31:0] elapsed_given;
    logic signed [31:0] row_time;
    logic [15:0]        row_target;
    logic signed [31:0] row_value;
    logic               row_undefined;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        fire_target;
    logic signed [31:0] fire_value;
    logic               fire_undefined;
    logic signed [31:0] fire_time;
    logic [9:0]         fire_index;
    logic               burst_last;
  } out_item_t;
endpackage

FILE: rtl/timed_event_table_sequencer.sv
// Timed event table sequencer: one memory, one comparator, one sequencer.
// Items are taken one at a time. Clear, start and advance finish in the
// idle state; append writes its row from S_APP. Finish bubble-sorts the
// table through the single memory port: each pass reads the first row,
// then each neighbor pair is compared and, when out of order, swapped by
// two writes. A tick reads the next row, compares its time against
// elapsed with the one shared comparator and stages it if due; a row can
// wait on output stalls, and the first row that is not yet due ends the
// tick, as do the end of the table and MAX_BURST rows. S_TOUT then hands
// the staged last row to the output register with burst_last set, and the
// input stays not ready until that last transfer is taken.
// Rows live in one single-port memory of MAX_EVENTS entries with registered
// read data; no clearing pass is needed after reset.
module timed_event_table_sequencer #(
  parameter int unsigned MAX_EVENTS = tets_pkg::MaxEventsDef,
  parameter int unsigned MAX_BURST  = tets_pkg::MaxBurstDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tets_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tets_pkg::out_item_t  out_data_o
);
  localparam int unsigned AW = $clog2(MAX_EVENTS);
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned BW = $clog2(MAX_BURST + 1);
  localparam int unsigned RW = 81;

  typedef enum logic [3:0] {
    S_IDLE, S_APP, S_SRD0, S_SRD1, S_SCMP, S_SWR1, S_TRD, S_TWAIT, S_TCMP, S_TOUT
  } state_e;

  // row layout: {time[80:49], target[48:33], undef[32], value[31:0]}
  logic [RW-1:0] mem [MAX_EVENTS];
  logic [RW-1:0] rd_q, a_q, b_q;
  logic [AW-1:0] addr_q;
  state_e        state_q;
  logic [CW-1:0] row_cnt_q, next_q, k_q, lim_q;
  logic [BW-1:0] burst_q;
  logic signed [39:0] start_q, elapsed_q;
  logic          valid_q, enable_q;
  logic          out_v_q, stg_v_q;
  tets_pkg::out_item_t out_q, stg_q;
  tets_pkg::in_item_t  in_q;

  // the one shared compare: a < b on signed 40-bit operands
  logic signed [39:0] cmp_a, cmp_b;
  logic cmp_lt;
  always_comb begin
    if (state_q == S_SCMP) begin
      cmp_a = 40'(signed'(rd_q[80:49]));
      cmp_b = 40'(signed'(a_q[80:49]));
    end else begin
      cmp_a = elapsed_q;
      cmp_b = 40'(signed'(rd_q[80:49]));
    end
    cmp_lt = cmp_a < cmp_b;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_valid_i) begin
      enable_q <= cfg_data_i;
    end
  end

  // staged row moves to the output once the next decision is known
  logic                out_free, out_load;
  tets_pkg::out_item_t out_next;
  always_comb begin
    out_free = !out_v_q || out_ready_i;
    out_load = 1'b0;
    out_next = stg_q;
    if (state_q == S_TCMP && !cmp_lt && stg_v_q && out_free) begin
      out_load = 1'b1;
    end else if (state_q == S_TOUT && stg_v_q && out_free) begin
      out_load = 1'b1;
      out_next.burst_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      out_q   <= '0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
      out_q   <= out_next;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  // memory: one port, registered read
  logic          we;
  logic [RW-1:0] wdata;
  always_comb begin
    we = 1'b0;
    wdata = b_q;
    if (state_q == S_APP) begin
      we = row_cnt_q < CW'(MAX_EVENTS);
      wdata = {in_q.row_time, in_q.row_target, in_q.row_undefined, in_q.row_value};
    end else if (state_q == S_SCMP) begin
      we = cmp_lt;
      wdata = a_q;
    end else if (state_q == S_SWR1) begin
      we = 1'b1;
      wdata = b_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (we) mem[addr_q] <= wdata;
    rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_cnt_q <= '0;
      next_q    <= '0;
      start_q   <= '0;
      elapsed_q <= '0;
      valid_q   <= 1'b0;
      stg_v_q   <= 1'b0;
      stg_q     <= '0;
      in_q      <= '0;
      a_q       <= '0;
      b_q       <= '0;
      k_q       <= '0;
      lim_q     <= '0;
      burst_q   <= '0;
      addr_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            in_q <= in_data_i;
            unique case (in_data_i.cmd)
              tets_pkg::CmdClear: begin
                row_cnt_q <= '0;
                valid_q   <= 1'b0;
              end
              tets_pkg::CmdAppend: begin
                valid_q <= 1'b0;
                addr_q  <= row_cnt_q[AW-1:0];
                state_q <= S_APP;
              end
              tets_pkg::CmdFinish: begin
                valid_q <= row_cnt_q != '0;
                if (row_cnt_q > CW'(1)) begin
                  lim_q     <= row_cnt_q - CW'(1);
                  k_q       <= '0;
                  addr_q    <= '0;
                  state_q   <= S_SRD0;
                end
              end
              tets_pkg::CmdStart: begin
                start_q   <= 40'(in_data_i.now_time);
                elapsed_q <= '0;
                next_q    <= '0;
              end
              tets_pkg::CmdAdvance: begin
                elapsed_q <= 40'(in_data_i.elapsed_given);
                start_q   <= 40'(in_data_i.now_time) - 40'(in_data_i.elapsed_given);
              end
              tets_pkg::CmdTick: begin
                if (enable_q && valid_q) begin
                  elapsed_q <= 40'(in_data_i.now_time) - start_q;
                  burst_q   <= '0;
                  addr_q    <= next_q[AW-1:0];
                  state_q   <= S_TRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_APP: begin
          if (row_cnt_q < CW'(MAX_EVENTS)) row_cnt_q <= row_cnt_q + CW'(1);
          state_q <= S_IDLE;
        end
        // sort: read row k, then row k+1, compare, swap by two writes
        S_SRD0: state_q <= S_SRD1;
        S_SRD1: begin
          a_q     <= rd_q;
          addr_q  <= addr_q + AW'(1);
          state_q <= S_TWAIT;
        end
        S_TWAIT: begin
          // shared wait state: in sort it lets row k+1 arrive
          state_q <= (lim_q != '0 && k_q <= lim_q && in_q.cmd == tets_pkg::CmdFinish)
                     ? S_SCMP : S_TCMP;
        end
        S_SCMP: begin
          // write a at k+1 on swap (addr points there), keep row k+1 in b
          b_q <= rd_q;
          if (cmp_lt) begin
            addr_q    <= addr_q - AW'(1);
            state_q   <= S_SWR1;
          end else if (k_q + CW'(2) >= lim_q + CW'(1)) begin
            // end of pass
            if (lim_q == CW'(1)) begin
              state_q <= S_IDLE; lim_q <= '0;
            end else begin
              lim_q <= lim_q - CW'(1); k_q <= '0; addr_q <= '0; state_q <= S_SRD0;
            end
          end else begin
            a_q     <= rd_q;
            k_q     <= k_q + CW'(1);
            addr_q  <= addr_q + AW'(1);
            state_q <= S_TWAIT;
          end
        end
        S_SWR1: begin
          // b written at k; a stays the larger row and moves on
          if (k_q + CW'(2) >= lim_q + CW'(1)) begin
            if (lim_q == CW'(1)) begin
              state_q <= S_IDLE; lim_q <= '0;
            end else begin
              lim_q <= lim_q - CW'(1); k_q <= '0; addr_q <= '0; state_q <= S_SRD0;
            end
          end else begin
            k_q     <= k_q + CW'(1);
            addr_q  <= addr_q + AW'(2);
            state_q <= S_TWAIT;
          end
        end
        // tick
        S_TRD: begin
          if (burst_q == BW'(MAX_BURST) || next_q >= row_cnt_q) begin
            state_q <= S_TOUT;
          end else begin
            state_q <= S_TWAIT;
          end
        end
        S_TCMP: begin
          if (cmp_lt) begin
            state_q <= S_TOUT;
          end else if (!stg_v_q || out_free) begin
            stg_v_q <= 1'b1;
            stg_q.fire_target    <= rd_q[48:33];
            stg_q.fire_value     <= rd_q[31:0];
            stg_q.fire_undefined <= rd_q[32];
            stg_q.fire_time      <= rd_q[80:49];
            stg_q.fire_index     <= 10'(next_q);
            stg_q.burst_last     <= 1'b0;
            next_q  <= next_q + CW'(1);
            burst_q <= burst_q + BW'(1);
            addr_q  <= addr_q + AW'(1);
            state_q <= S_TRD;
          end
        end
        S_TOUT: begin
          // the staged row, if any, is the last of this tick
          if (!stg_v_q || out_free) begin
            stg_v_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/tets_checker.sv
// Port-level checker for the timed event table sequencer, with its bind.
`include "timed_event_table_sequencer_assert.svh"
module tets_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tets_pkg::out_item_t out_data_o
);
  `TETS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `TETS_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  `TETS_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `TETS_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i)
endmodule

bind timed_event_table_sequencer tets_checker u_tets_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
